// ===== hdl/pid_filtered_derivative_controller_macros.svh =====
// Assertion macros shared by the PID controller RTL.
// Needs nothing else; files that assert include this header by name.
`ifndef PID_FILTERED_DERIVATIVE_CONTROLLER_MACROS_SVH
`define PID_FILTERED_DERIVATIVE_CONTROLLER_MACROS_SVH

// Concurrent check on the rising clock edge, switched off while reset is low.
`define PFD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Concurrent check on the rising clock edge that also holds during reset.
`define PFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== hdl/pfd_pkg.sv =====
// Shared types and constants of the filtered-derivative PID controller.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package pfd_pkg;

    // Field and register widths.
    localparam int SAMPLE_WIDTH        = 16;
    localparam int COEF_WIDTH          = 32;
    localparam int ALPHA_WIDTH         = 18;
    localparam int ALPHA_FRAC_BITS     = 16;
    localparam int DRIVE_WIDTH         = 32;
    localparam int CFG_INDEX_WIDTH     = 3;
    localparam int CFG_DATA_WIDTH      = 32;

    // Defaults of the top-level parameters.
    localparam int DEF_ACC_WIDTH       = 48;
    localparam int DEF_COEF_FRAC_BITS  = 16;

    // Error and second difference of the error.
    localparam int ERR_WIDTH           = SAMPLE_WIDTH + 1;
    localparam int SECOND_WIDTH        = SAMPLE_WIDTH + 3;

    // Shared multiplier: wide operands are split into a 32-bit unsigned low
    // half and a signed high half that covers accumulator widths up to 64.
    localparam int SPLIT_LO_WIDTH      = 32;
    localparam int SPLIT_WIDTH         = 66;
    localparam int MUL_A_WIDTH         = COEF_WIDTH + 1;
    localparam int MUL_B_WIDTH         = SPLIT_WIDTH - SPLIT_LO_WIDTH + 1;
    localparam int MUL_P_WIDTH         = MUL_A_WIDTH + MUL_B_WIDTH;

    // Extra accumulator bits above the derivative width.
    localparam int FILTER_GUARD        = 20;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_ERROR_NOW   = 3'd0,
        CFG_ERROR_PREV  = 3'd1,
        CFG_DERIVATIVE  = 3'd2,
        CFG_ALPHA_ONE   = 3'd3,
        CFG_ALPHA_TWO   = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0]  coef_error_now;
        logic signed [COEF_WIDTH-1:0]  coef_error_prev;
        logic signed [COEF_WIDTH-1:0]  coef_derivative;
        logic signed [ALPHA_WIDTH-1:0] filter_alpha_one;
        logic signed [ALPHA_WIDTH-1:0] filter_alpha_two;
    } t_cfg;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] setpoint;
        logic signed [SAMPLE_WIDTH-1:0] measured;
        logic signed [DRIVE_WIDTH-1:0]  previous_drive;
    } t_in_item;

    typedef struct packed {
        logic signed [DRIVE_WIDTH-1:0] drive;
        logic                          saturated;
    } t_out_item;

    // Sequencer states, one per step of the computation.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_D,
        ST_SAT_D,
        ST_SUM_D,
        ST_FLT_LO,
        ST_FLT_HI,
        ST_FLT_END,
        ST_FLT_RND,
        ST_PRP_ERR,
        ST_PRP_FD,
        ST_RND,
        ST_OUT
    } t_state;

    // Operand pair fed to the shared multiplier.
    typedef enum logic [2:0] {
        MS_KD_SECOND,
        MS_AL2_LO,
        MS_AL2_HI,
        MS_AL1_LO,
        MS_AL1_HI,
        MS_A0_E0,
        MS_A1_E1
    } t_mul_sel;

    // Accumulator operation on the registered product.
    typedef enum logic [2:0] {
        AO_HOLD,
        AO_LOAD,
        AO_LOAD_NEG,
        AO_ADD,
        AO_ADD_HI,
        AO_SUB_HI,
        AO_ADD_FD,
        AO_ROUND
    } t_acc_op;

    // Control word from the sequencer to the datapath.
    typedef struct packed {
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        logic     load_item;
        logic     sat_d;
        logic     sum_d;
        logic     end_fd;
        logic     commit;
    } t_ctrl;

endpackage

// ===== hdl/pfd_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on pfd_pkg for the operand widths.
`timescale 1ns / 1ps

module pfd_mul (
    input  logic                                 i_clk,
    input  logic signed [pfd_pkg::MUL_A_WIDTH-1:0] i_a,
    input  logic signed [pfd_pkg::MUL_B_WIDTH-1:0] i_b,
    output logic signed [pfd_pkg::MUL_P_WIDTH-1:0] o_prod
);
    import pfd_pkg::*;

    logic signed [MUL_P_WIDTH-1:0] r_prod;

    // One product per cycle, registered before any further arithmetic.
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

// ===== hdl/pfd_seq.sv =====
// Step sequencer of the PID controller: walks one item through the shared
// multiplier and accumulator. Depends on pfd_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "pid_filtered_derivative_controller_macros.svh"

module pfd_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_out_free,
    output logic           o_in_stall,
    output pfd_pkg::t_ctrl o_ctrl
);
    import pfd_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: a fixed walk through the steps, waiting only at both ends.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (i_in_valid) n_state = ST_MUL_D;
            ST_MUL_D:   n_state = ST_SAT_D;
            ST_SAT_D:   n_state = ST_SUM_D;
            ST_SUM_D:   n_state = ST_FLT_LO;
            ST_FLT_LO:  n_state = ST_FLT_HI;
            ST_FLT_HI:  n_state = ST_FLT_END;
            ST_FLT_END: n_state = ST_FLT_RND;
            ST_FLT_RND: n_state = ST_PRP_ERR;
            ST_PRP_ERR: n_state = ST_PRP_FD;
            ST_PRP_FD:  n_state = ST_RND;
            ST_RND:     n_state = ST_OUT;
            ST_OUT:     if (i_out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Control outputs. From ST_MUL_D to ST_FLT_RND each step issues one product;
    // each step from ST_SAT_D to ST_PRP_ERR consumes the product of the step before.
    always_comb begin
        o_ctrl.mul_sel   = MS_A1_E1;
        o_ctrl.acc_op    = AO_HOLD;
        o_ctrl.load_item = 1'b0;
        o_ctrl.sat_d     = 1'b0;
        o_ctrl.sum_d     = 1'b0;
        o_ctrl.end_fd    = 1'b0;
        o_ctrl.commit    = 1'b0;
        o_in_stall       = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                o_ctrl.load_item = i_in_valid;
            end
            ST_MUL_D: begin
                o_ctrl.mul_sel = MS_KD_SECOND;
            end
            ST_SAT_D: begin
                o_ctrl.sat_d   = 1'b1;
                o_ctrl.mul_sel = MS_AL2_LO;
            end
            ST_SUM_D: begin
                o_ctrl.sum_d   = 1'b1;
                o_ctrl.acc_op  = AO_LOAD_NEG;
                o_ctrl.mul_sel = MS_AL2_HI;
            end
            ST_FLT_LO: begin
                o_ctrl.acc_op  = AO_SUB_HI;
                o_ctrl.mul_sel = MS_AL1_LO;
            end
            ST_FLT_HI: begin
                o_ctrl.acc_op  = AO_ADD;
                o_ctrl.mul_sel = MS_AL1_HI;
            end
            ST_FLT_END: begin
                o_ctrl.acc_op  = AO_ADD_HI;
                o_ctrl.mul_sel = MS_A0_E0;
            end
            ST_FLT_RND: begin
                o_ctrl.end_fd  = 1'b1;
                o_ctrl.acc_op  = AO_LOAD;
                o_ctrl.mul_sel = MS_A1_E1;
            end
            ST_PRP_ERR: begin
                o_ctrl.acc_op = AO_ADD;
            end
            ST_PRP_FD: begin
                o_ctrl.acc_op = AO_ADD_FD;
            end
            ST_RND: begin
                o_ctrl.acc_op = AO_ROUND;
            end
            ST_OUT: begin
                o_ctrl.commit = i_out_free;
            end
            default: begin
                o_ctrl.acc_op = AO_HOLD;
            end
        endcase
    end

    // An accepted item always starts with the derivative product.
    `PFD_ASSERT(a_accept_starts, i_clk, i_rst_n, (r_state == ST_IDLE && i_in_valid) |=> (r_state == ST_MUL_D), "accepted item did not start the sequence")
    // A finished result waits while the output register is still occupied.
    `PFD_ASSERT(a_out_waits, i_clk, i_rst_n, (r_state == ST_OUT && !i_out_free) |=> (r_state == ST_OUT), "result left before the output register was free")
    // Reset always brings the sequencer back to idle.
    `PFD_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (r_state == ST_IDLE), "sequencer not idle after reset")

endmodule

// ===== hdl/pfd_dp.sv =====
// Datapath of the PID controller: operand selection, shared multiplier,
// accumulator, rounding, saturation and loop state. Depends on pfd_pkg, pfd_mul.
`timescale 1ns / 1ps

module pfd_dp #(
    parameter int ACC_WIDTH      = pfd_pkg::DEF_ACC_WIDTH,
    parameter int COEF_FRAC_BITS = pfd_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  pfd_pkg::t_ctrl                        i_ctrl,
    input  pfd_pkg::t_cfg                         i_cfg,
    input  pfd_pkg::t_in_item                     i_item,
    output logic signed [pfd_pkg::DRIVE_WIDTH-1:0] o_drive,
    output logic                                  o_saturated
);
    import pfd_pkg::*;

    localparam int AW     = ACC_WIDTH + FILTER_GUARD;
    localparam int DSUM_W = ACC_WIDTH + 1;

    localparam logic signed [ACC_WIDTH-1:0]   ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0]   ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    localparam logic signed [DRIVE_WIDTH-1:0] DRV_MAX = {1'b0, {(DRIVE_WIDTH-1){1'b1}}};
    localparam logic signed [DRIVE_WIDTH-1:0] DRV_MIN = {1'b1, {(DRIVE_WIDTH-1){1'b0}}};
    localparam logic signed [AW-1:0] FD_HALF =
        {{(AW-ALPHA_FRAC_BITS){1'b0}}, 1'b1, {(ALPHA_FRAC_BITS-1){1'b0}}};
    localparam logic signed [AW-1:0] DRV_HALF =
        {{(AW-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};

    // Item registers.
    logic signed [ERR_WIDTH-1:0]    r_e0;
    logic signed [SECOND_WIDTH-1:0] r_second;
    logic signed [DRIVE_WIDTH-1:0]  r_prev;

    // Loop state carried from item to item.
    logic signed [ERR_WIDTH-1:0]    r_el;
    logic signed [ERR_WIDTH-1:0]    r_ebl;
    logic signed [ACC_WIDTH-1:0]    r_dl;
    logic signed [ACC_WIDTH-1:0]    r_fdl;

    // Intermediate results of the current item.
    logic signed [ACC_WIDTH-1:0]    r_d;
    logic signed [ACC_WIDTH-1:0]    r_fd;
    logic signed [DSUM_W-1:0]       r_dsum;
    logic signed [AW-1:0]           r_acc;
    logic                           r_flag;

    logic signed [ERR_WIDTH-1:0]    e0_new;
    logic signed [SECOND_WIDTH-1:0] second_new;
    logic signed [SPLIT_WIDTH-1:0]  fdl_ext;
    logic signed [SPLIT_WIDTH-1:0]  dsum_ext;
    logic signed [MUL_A_WIDTH-1:0]  mul_a;
    logic signed [MUL_B_WIDTH-1:0]  mul_b;
    logic signed [MUL_P_WIDTH-1:0]  prod;
    logic signed [AW-1:0]           prod_ext;
    logic signed [AW-1:0]           prod_hi;

    logic signed [ACC_WIDTH-1:0]    d_trunc;
    logic                           d_fit;
    logic signed [ACC_WIDTH-1:0]    d_sat;

    logic signed [AW-1:0]           fd_round;
    logic signed [ACC_WIDTH-1:0]    fd_trunc;
    logic                           fd_fit;
    logic signed [ACC_WIDTH-1:0]    fd_sat;

    logic signed [AW-1:0]           acc_base;
    logic signed [AW-1:0]           acc_addend;
    logic                           acc_sub;
    logic signed [AW-1:0]           acc_sum;
    logic signed [AW-1:0]           n_acc;

    logic signed [AW-1:0]           drive_sum;
    logic signed [DRIVE_WIDTH-1:0]  drive_trunc;
    logic                           drive_fit;

    // Error and its second difference, formed as the item is taken in.
    assign e0_new     = ERR_WIDTH'(i_item.setpoint) - ERR_WIDTH'(i_item.measured);
    assign second_new = SECOND_WIDTH'(e0_new) - (SECOND_WIDTH'(r_el) <<< 1)
                      + SECOND_WIDTH'(r_ebl);

    // Wide operands split into an unsigned low half and a signed high half.
    assign fdl_ext  = SPLIT_WIDTH'(r_fdl);
    assign dsum_ext = SPLIT_WIDTH'(r_dsum);

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = MUL_A_WIDTH'(i_cfg.coef_error_prev);
        mul_b = MUL_B_WIDTH'(r_el);
        unique case (i_ctrl.mul_sel)
            MS_KD_SECOND: begin
                mul_a = MUL_A_WIDTH'(i_cfg.coef_derivative);
                mul_b = MUL_B_WIDTH'(r_second);
            end
            MS_AL2_LO: begin
                mul_a = MUL_A_WIDTH'(i_cfg.filter_alpha_two);
                mul_b = $signed({{(MUL_B_WIDTH-SPLIT_LO_WIDTH){1'b0}},
                                 fdl_ext[SPLIT_LO_WIDTH-1:0]});
            end
            MS_AL2_HI: begin
                mul_a = MUL_A_WIDTH'(i_cfg.filter_alpha_two);
                mul_b = MUL_B_WIDTH'($signed(fdl_ext[SPLIT_WIDTH-1:SPLIT_LO_WIDTH]));
            end
            MS_AL1_LO: begin
                mul_a = MUL_A_WIDTH'(i_cfg.filter_alpha_one);
                mul_b = $signed({{(MUL_B_WIDTH-SPLIT_LO_WIDTH){1'b0}},
                                 dsum_ext[SPLIT_LO_WIDTH-1:0]});
            end
            MS_AL1_HI: begin
                mul_a = MUL_A_WIDTH'(i_cfg.filter_alpha_one);
                mul_b = MUL_B_WIDTH'($signed(dsum_ext[SPLIT_WIDTH-1:SPLIT_LO_WIDTH]));
            end
            MS_A0_E0: begin
                mul_a = MUL_A_WIDTH'(i_cfg.coef_error_now);
                mul_b = MUL_B_WIDTH'(r_e0);
            end
            MS_A1_E1: begin
                mul_a = MUL_A_WIDTH'(i_cfg.coef_error_prev);
                mul_b = MUL_B_WIDTH'(r_el);
            end
            default: begin
                mul_a = MUL_A_WIDTH'(i_cfg.coef_error_prev);
                mul_b = MUL_B_WIDTH'(r_el);
            end
        endcase
    end

    pfd_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign prod_ext = AW'(prod);
    assign prod_hi  = AW'(prod) <<< SPLIT_LO_WIDTH;

    // Raw derivative clipped to the accumulator width.
    assign d_trunc = ACC_WIDTH'(prod);
    assign d_fit   = (MUL_P_WIDTH'(d_trunc) == prod);
    assign d_sat   = d_fit ? d_trunc : (prod[MUL_P_WIDTH-1] ? ACC_MIN : ACC_MAX);

    // Filtered derivative: round half up by the filter fraction, then clip.
    assign fd_round = (r_acc + FD_HALF) >>> ALPHA_FRAC_BITS;
    assign fd_trunc = ACC_WIDTH'(fd_round);
    assign fd_fit   = (AW'(fd_trunc) == fd_round);
    assign fd_sat   = fd_fit ? fd_trunc : (fd_round[AW-1] ? ACC_MIN : ACC_MAX);

    // Accumulator: one adder, with subtraction by inversion and carry in.
    always_comb begin
        acc_base   = r_acc;
        acc_addend = '0;
        acc_sub    = 1'b0;
        unique case (i_ctrl.acc_op)
            AO_HOLD: begin
                acc_addend = '0;
            end
            AO_LOAD: begin
                acc_base   = '0;
                acc_addend = prod_ext;
            end
            AO_LOAD_NEG: begin
                acc_base   = '0;
                acc_addend = prod_ext;
                acc_sub    = 1'b1;
            end
            AO_ADD: begin
                acc_addend = prod_ext;
            end
            AO_ADD_HI: begin
                acc_addend = prod_hi;
            end
            AO_SUB_HI: begin
                acc_addend = prod_hi;
                acc_sub    = 1'b1;
            end
            AO_ADD_FD: begin
                acc_addend = AW'(r_fd);
            end
            AO_ROUND: begin
                acc_addend = DRV_HALF;
            end
            default: begin
                acc_addend = '0;
            end
        endcase
    end

    assign acc_sum = acc_base + (acc_sub ? ~acc_addend : acc_addend)
                   + {{(AW-1){1'b0}}, acc_sub};

    always_comb begin
        priority if (i_ctrl.acc_op == AO_ROUND) begin
            n_acc = acc_sum >>> COEF_FRAC_BITS;
        end else if (i_ctrl.acc_op == AO_HOLD) begin
            n_acc = r_acc;
        end else begin
            n_acc = acc_sum;
        end
    end

    // Drive: rounded sum plus the previous drive, clipped to 32 bits.
    assign drive_sum   = r_acc + AW'(r_prev);
    assign drive_trunc = DRIVE_WIDTH'(drive_sum);
    assign drive_fit   = (AW'(drive_trunc) == drive_sum);
    assign o_drive     = drive_fit ? drive_trunc : (drive_sum[AW-1] ? DRV_MIN : DRV_MAX);
    assign o_saturated = r_flag | ~drive_fit;

    // Working registers of the current item.
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (i_ctrl.load_item) begin
            r_e0     <= e0_new;
            r_second <= second_new;
            r_prev   <= i_item.previous_drive;
        end
        if (i_ctrl.sat_d) begin
            r_d <= d_sat;
        end
        if (i_ctrl.sum_d) begin
            r_dsum <= DSUM_W'(r_d) + DSUM_W'(r_dl);
        end
        if (i_ctrl.end_fd) begin
            r_fd <= fd_sat;
        end
    end

    // Clip flag and loop state; the state moves on when the result is handed over.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b0;
            r_el   <= '0;
            r_ebl  <= '0;
            r_dl   <= '0;
            r_fdl  <= '0;
        end else begin
            if (i_ctrl.load_item) begin
                r_flag <= 1'b0;
            end else if (i_ctrl.sat_d) begin
                r_flag <= r_flag | ~d_fit;
            end else if (i_ctrl.end_fd) begin
                r_flag <= r_flag | ~fd_fit;
            end
            if (i_ctrl.commit) begin
                r_ebl <= r_el;
                r_el  <= r_e0;
                r_dl  <= r_d;
                r_fdl <= r_fd;
            end
        end
    end

endmodule

// ===== hdl/pid_filtered_derivative_controller.sv =====
// Top level of the incremental PID controller with a filtered derivative.
// Depends on pfd_pkg, pfd_seq, pfd_dp and the assertion macros.
`timescale 1ns / 1ps
`include "pid_filtered_derivative_controller_macros.svh"

// One input transfer carries setpoint, measurement and the previous drive and
// produces exactly one output transfer with the new drive and a clip flag. The
// block works on one item at a time: a step runs through one shared multiplier
// under a small sequencer, seven products in all, and the input stalls from the
// input transfer until the result is in the output register and the sequencer
// is back in idle. The output register lets a finished result wait for the
// consumer while a new item is taken; a second result waits in the datapath
// until the register is free. The user must write coefficients through the
// configuration port only while the block is idle; the block does not enforce
// this. There is no clearing pass after reset.
module pid_filtered_derivative_controller #(
    parameter int ACC_WIDTH      = pfd_pkg::DEF_ACC_WIDTH,
    parameter int COEF_FRAC_BITS = pfd_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration writes.
    input  logic                                  i_cfg_we,
    input  logic [pfd_pkg::CFG_INDEX_WIDTH-1:0]   i_cfg_index,
    input  logic [pfd_pkg::CFG_DATA_WIDTH-1:0]    i_cfg_data,
    // Input channel.
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  pfd_pkg::t_in_item                     i_in_data,
    // Output channel.
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output pfd_pkg::t_out_item                    o_out_data
);
    import pfd_pkg::*;

    t_cfg      r_cfg;
    t_ctrl     ctrl;
    logic      r_out_valid;
    t_out_item r_out_data;
    logic      out_free;
    logic signed [DRIVE_WIDTH-1:0] dp_drive;
    logic      dp_saturated;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ERROR_NOW:  r_cfg.coef_error_now   <= i_cfg_data;
                CFG_ERROR_PREV: r_cfg.coef_error_prev  <= i_cfg_data;
                CFG_DERIVATIVE: r_cfg.coef_derivative  <= i_cfg_data;
                CFG_ALPHA_ONE:  r_cfg.filter_alpha_one <= i_cfg_data[ALPHA_WIDTH-1:0];
                CFG_ALPHA_TWO:  r_cfg.filter_alpha_two <= i_cfg_data[ALPHA_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    // The output register can take a result when empty or being drained.
    assign out_free = ~r_out_valid | ~i_out_stall;

    pfd_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .o_in_stall (o_in_stall),
        .o_ctrl     (ctrl)
    );

    pfd_dp #(
        .ACC_WIDTH      (ACC_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_cfg       (r_cfg),
        .i_item      (i_in_data),
        .o_drive     (dp_drive),
        .o_saturated (dp_saturated)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.commit) begin
            r_out_data.drive     <= dp_drive;
            r_out_data.saturated <= dp_saturated;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // A handed-over result is visible on the output in the next cycle.
    `PFD_ASSERT(a_commit_shows, i_clk, i_rst_n, ctrl.commit |=> r_out_valid, "result handed over but output not valid")
    // After an input transfer the block is busy.
    `PFD_ASSERT(a_busy_after_in, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall, "input taken again right after a transfer")
    // Output valid only rises when the datapath handed over a result.
    `PFD_ASSERT(a_valid_source, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(ctrl.commit), "output valid without a finished result")

endmodule
